[src/bstl_pkg.sv]
package bstl_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CHANNELS = 32;

	typedef enum logic [1:0] {
		OP_LOOKUP_LE = 2'd0,
		OP_LOOKUP_GE = 2'd1,
		OP_WRITE     = 2'd2,
		OP_READ      = 2'd3
	} op_t;

	localparam logic [1:0] CFG_ROWS_IN_USE     = 2'd0;
	localparam logic [1:0] CFG_BANKS_IN_USE    = 2'd1;
	localparam logic [1:0] CFG_CHANNELS_IN_USE = 2'd2;

	typedef struct packed {
		op_t                        operation;
		logic [2:0]                 bank;
		logic [4:0]                 channel;
		logic [3:0]                 row;
		logic signed [SAMPLE_W-1:0] sample_key;
		logic signed [SAMPLE_W-1:0] entry_value;
		logic                       use_active_limits;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] result_value;
		logic signed [SAMPLE_W-1:0] read_key;
	} out_t;

	typedef struct packed {
		logic [4:0] rows_in_use;
		logic [3:0] banks_in_use;
		logic [5:0] channels_in_use;
	} cfg_t;

endpackage

[src/banked_stepwise_threshold_lookup.sv]
// Banked threshold lookup: one key/value table of ROWS rows per bank, held
// in a single synchronous RAM of BANKS*ROWS words.
// Command channel: an item is taken on a rising edge with start high and busy
// low. Lookups scan the active rows of the bank one row per cycle and return
// the value of the first matching row (LE or GE compare), else zero. Writes
// and reads touch one row.
// Result channel: done is high for exactly one cycle with the word on result;
// the receiver has no way to stall it, and busy may already be low in that
// same cycle, so the next item can be taken while the result is shown.
// Latency in cycles from the accepting edge to the done cycle:
//   write, or lookup rejected by limits or no active rows: 1
//   read: 2
//   lookup ending at row r: r + 2, so up to min(rows_in_use, ROWS) + 1
// The scan is bound by the RAM read port: one row per cycle.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once
// and are accepted at any time, including during the clearing sweep.
// Reset: registers clear, then the block stays busy for BANKS*ROWS cycles
// while it zeroes every table entry.
module banked_stepwise_threshold_lookup import bstl_pkg::*; #(
	parameter int ROWS  = 16,
	parameter int BANKS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  in_t        item,
	output logic       done,
	output out_t       result,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data
);

	localparam int DEPTH = BANKS * ROWS;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

	cfg_t                  cfg_q;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [2*SAMPLE_W-1:0] ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [2*SAMPLE_W-1:0] ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_ROWS_IN_USE:     cfg_q.rows_in_use     <= cfg_data[4:0];
				CFG_BANKS_IN_USE:    cfg_q.banks_in_use    <= cfg_data[3:0];
				CFG_CHANNELS_IN_USE: cfg_q.channels_in_use <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	bstl_seq #(
		.ROWS  (ROWS),
		.BANKS (BANKS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	bstl_ram #(
		.W     (2 * SAMPLE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

[src/bstl_ram.sv]
module bstl_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [W-1:0]                           wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [W-1:0]                           rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/bstl_seq.sv]
module bstl_seq import bstl_pkg::*; #(
	parameter int ROWS  = 16,
	parameter int BANKS = 8
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  cfg_t                                              cfg,
	input  logic                                              start,
	input  in_t                                               item,
	output logic                                              busy,
	output logic                                              done,
	output out_t                                              result,
	output logic                                              ram_we,
	output logic [(BANKS*ROWS > 1 ? $clog2(BANKS*ROWS) : 1)-1:0] ram_waddr,
	output logic [2*SAMPLE_W-1:0]                             ram_wdata,
	output logic                                              ram_re,
	output logic [(BANKS*ROWS > 1 ? $clog2(BANKS*ROWS) : 1)-1:0] ram_raddr,
	input  logic [2*SAMPLE_W-1:0]                             ram_rdata
);

	localparam int DEPTH = BANKS * ROWS;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int ROW_W = ROWS > 1 ? $clog2(ROWS) : 1;

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_READ} state_t;

	state_t                     state_q;
	logic [AW-1:0]              clr_q;
	logic [AW-1:0]              base_q;
	logic [ROW_W-1:0]           cnt_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       ge_q;
	logic                       ok_q;
	logic                       done_q;
	out_t                       res_q;

	logic                       acc;
	logic                       is_lookup;
	logic                       bank_ok;
	logic                       row_ok;
	logic                       look_ok;
	logic [AW-1:0]              addr_in;
	logic [AW-1:0]              base_in;
	logic signed [SAMPLE_W-1:0] rd_key;
	logic signed [SAMPLE_W-1:0] rd_val;
	logic                       match;
	logic                       last;

	assign acc       = start && (state_q == ST_IDLE);
	assign is_lookup = (item.operation == OP_LOOKUP_LE) || (item.operation == OP_LOOKUP_GE);
	assign bank_ok   = int'(item.bank) < BANKS;
	assign row_ok    = int'(item.row) < ROWS;
	assign base_in   = AW'(int'(item.bank) * ROWS);
	assign addr_in   = AW'(int'(item.bank) * ROWS + int'(item.row));

	// min(limit, size) compare split into two compares
	assign look_ok = bank_ok && (cfg.rows_in_use != '0) && !(item.use_active_limits && (
		int'(item.bank) >= int'(cfg.banks_in_use) ||
		int'(item.channel) >= int'(cfg.channels_in_use) ||
		int'(item.channel) >= CHANNELS));

	assign rd_key = ram_rdata[2*SAMPLE_W-1:SAMPLE_W];
	assign rd_val = ram_rdata[SAMPLE_W-1:0];
	assign match  = ge_q ? (rd_key >= sample_q) : (rd_key <= sample_q);
	assign last   = (int'(cnt_q) + 1 >= int'(cfg.rows_in_use)) || (int'(cnt_q) + 1 >= ROWS);

	// Writes only happen on the clear sweep or when a write word is taken in IDLE;
	// reads never share that edge, so no forwarding path is needed.
	always_comb begin
		ram_we    = (state_q == ST_CLEAR) ||
			(acc && item.operation == OP_WRITE && bank_ok && row_ok);
		ram_waddr = (state_q == ST_CLEAR) ? clr_q : addr_in;
		ram_wdata = (state_q == ST_CLEAR) ? '0 : {item.sample_key, item.entry_value};
		ram_re    = (acc && item.operation != OP_WRITE) || (state_q == ST_SCAN);
		if (state_q == ST_SCAN) begin
			ram_raddr = AW'(int'(base_q) + int'(cnt_q) + 1);
		end else begin
			ram_raddr = is_lookup ? base_in : addr_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			done_q   <= 1'b0;
			sample_q <= '0;
			ge_q     <= 1'b0;
			ok_q     <= 1'b0;
			base_q   <= '0;
			cnt_q    <= '0;
			res_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						sample_q <= item.sample_key;
						ge_q     <= item.operation == OP_LOOKUP_GE;
						ok_q     <= bank_ok && row_ok;
						base_q   <= base_in;
						cnt_q    <= '0;
						res_q    <= '0;
						unique case (item.operation)
							OP_LOOKUP_LE, OP_LOOKUP_GE: begin
								if (look_ok) begin
									state_q <= ST_SCAN;
								end else begin
									done_q <= 1'b1;
								end
							end
							OP_WRITE: begin
								done_q <= 1'b1;
							end
							OP_READ: begin
								state_q <= ST_READ;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (match) begin
						res_q.result_value <= rd_val;
						res_q.read_key     <= '0;
						done_q             <= 1'b1;
						state_q            <= ST_IDLE;
					end else if (last) begin
						res_q   <= '0;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_READ: begin
					res_q.result_value <= ok_q ? rd_val : '0;
					res_q.read_key     <= ok_q ? rd_key : '0;
					done_q             <= 1'b1;
					state_q            <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = res_q;

endmodule

[src/bstl_chk.sv]
module bstl_chk import bstl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input in_t  item,
	input logic done,
	input out_t result
);

	// a taken word either finishes next cycle or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted word neither answered nor in progress");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while block still busy");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy) || $fell(busy))
		else $error("result without a matching accept or finished scan");

	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.operation == OP_WRITE |=> done && result == '0)
		else $error("row write did not return a zero word");

endmodule

bind banked_stepwise_threshold_lookup bstl_chk u_chk (.*);

[bench/tb_banked_stepwise_threshold_lookup.sv]
module tb_banked_stepwise_threshold_lookup;
	import bstl_pkg::*;

	localparam int N_ROWS       = 16;
	localparam int N_BANKS      = 8;
	localparam int PHASES       = 6;
	localparam int PHASE_WORDS  = 150;
	localparam int SETTLE_CYCLES = 24;
	localparam int LIMIT_CYCLES = 200000;

	// index past the register list; writes there must be dropped
	localparam logic [1:0] CFG_SPARE = 2'd3;

	typedef struct {
		in_t  word;
		bit   known;
		out_t want;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	in_t        item;
	logic       done;
	out_t       result;
	logic       cfg_wr_en;
	logic [1:0] cfg_index;
	logic [5:0] cfg_data;

	logic signed [SAMPLE_W-1:0] key_mem [N_BANKS*N_ROWS];
	logic signed [SAMPLE_W-1:0] val_mem [N_BANKS*N_ROWS];
	logic [4:0] rows_reg;
	logic [3:0] banks_reg;
	logic [5:0] chans_reg;

	out_t        want_q [$];
	out_t        head;
	int unsigned errors;
	int unsigned cycles;
	int unsigned n_words;
	int unsigned n_checked;
	int unsigned n_hits;
	int unsigned n_settings;

	banked_stepwise_threshold_lookup uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (done) begin
			if (want_q.size() == 0) begin
				$error("result word with nothing pending: result_value %0d read_key %0d",
					result.result_value, result.read_key);
				errors++;
			end else begin
				head = want_q.pop_front();
				n_checked++;
				if (result.result_value !== head.result_value) begin
					$error("result_value: expected %0d, got %0d", head.result_value,
						result.result_value);
					errors++;
				end
				if (result.read_key !== head.read_key) begin
					$error("read_key: expected %0d, got %0d", head.read_key, result.read_key);
					errors++;
				end
			end
		end
	end

	function automatic int sat(int v, int top);
		return v > top ? top : v;
	endfunction

	// Expected result of one command; writes update the shadow tables.
	function automatic out_t threshold_lookup(in_t w);
		out_t r;
		int   addr;
		int   n;
		bit   pass;
		bit   hit;
		r = '0;
		addr = int'(w.bank) * N_ROWS + int'(w.row);
		case (w.operation)
			OP_WRITE: begin
				key_mem[addr] = w.sample_key;
				val_mem[addr] = w.entry_value;
			end
			OP_READ: begin
				r.read_key = key_mem[addr];
				r.result_value = val_mem[addr];
			end
			default: begin
				pass = 1'b1;
				if (w.use_active_limits) begin
					if (int'(w.bank) >= sat(banks_reg, N_BANKS))
						pass = 1'b0;
					if (int'(w.channel) >= sat(chans_reg, CHANNELS))
						pass = 1'b0;
				end
				n = pass ? sat(rows_reg, N_ROWS) : 0;
				hit = 1'b0;
				for (int i = 0; i < n && !hit; i++) begin
					addr = int'(w.bank) * N_ROWS + i;
					if (w.operation == OP_LOOKUP_GE ? key_mem[addr] >= w.sample_key
							: key_mem[addr] <= w.sample_key) begin
						r.result_value = val_mem[addr];
						hit = 1'b1;
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic in_t cmd(op_t op, int bank, int chan, int row, int key, int val,
			bit lim);
		in_t w;
		w.operation = op;
		w.bank = 3'(bank);
		w.channel = 5'(chan);
		w.row = 4'(row);
		w.sample_key = 16'(key);
		w.entry_value = 16'(val);
		w.use_active_limits = lim;
		return w;
	endfunction

	function automatic dir_row_t typed_row(in_t w, out_t want);
		dir_row_t d;
		d.word = w;
		d.known = 1'b1;
		d.want = want;
		return d;
	endfunction

	function automatic dir_row_t predicted_row(in_t w);
		dir_row_t d;
		d.word = w;
		d.known = 1'b0;
		d.want = '0;
		return d;
	endfunction

	// Mix extremes, full-range noise, small thresholds and near-hits on stored keys.
	function automatic logic signed [SAMPLE_W-1:0] pick_key(int bank);
		logic signed [SAMPLE_W-1:0] k;
		case ($urandom_range(0, 9))
			0: k = 16'sh8000;
			1: k = 16'sh7FFF;
			2, 3: k = 16'($urandom);
			4, 5, 6: k = 16'(int'($urandom_range(0, 400)) - 200);
			default: k = key_mem[bank*N_ROWS + $urandom_range(0, N_ROWS-1)]
				+ 16'(int'($urandom_range(0, 4)) - 2);
		endcase
		return k;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Called and returns at a falling edge.
	task automatic send_word(in_t w, int unsigned gap, bit known, out_t want);
		out_t r;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		item <= w;
		do @(posedge clk); while (busy);
		r = threshold_lookup(w);
		want_q.push_back(known ? want : r);
		n_words++;
		if (w.operation inside {OP_LOOKUP_LE, OP_LOOKUP_GE} && r.result_value != 0)
			n_hits++;
		@(negedge clk);
	endtask

	// Hold off until every pending word is back and the block has gone quiet.
	task automatic settle();
		start <= 1'b0;
		while (want_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [5:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_ROWS_IN_USE:     rows_reg = data[4:0];
			CFG_BANKS_IN_USE:    banks_reg = data[3:0];
			CFG_CHANNELS_IN_USE: chans_reg = data[5:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic program_regs(cfg_t c);
		reg_write(CFG_ROWS_IN_USE, {1'($urandom), c.rows_in_use});
		reg_write(CFG_BANKS_IN_USE, {2'($urandom), c.banks_in_use});
		reg_write(CFG_CHANNELS_IN_USE, c.channels_in_use);
		reg_write(CFG_SPARE, 6'($urandom));
		cfg_wr_en <= 1'b0;
		n_settings++;
	endtask

	initial begin
		dir_row_t    directed [$];
		cfg_t        regs_at [int];
		cfg_t        plan;
		in_t         w;
		int unsigned r;
		bit          quiet;

		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_ROWS_IN_USE;
		cfg_data = '0;
		foreach (key_mem[i]) begin
			key_mem[i] = '0;
			val_mem[i] = '0;
		end
		rows_reg = '0;
		banks_reg = '0;
		chans_reg = '0;

		// reset state: no active rows, no banks or channels enabled, tables clear
		directed.push_back(typed_row(cmd(OP_LOOKUP_LE, 0, 0, 0, 0, 0, 0), '0));
		directed.push_back(typed_row(cmd(OP_LOOKUP_GE, 7, 31, 0, -32768, 0, 1), '0));
		directed.push_back(typed_row(cmd(OP_READ, 7, 0, 15, 0, 0, 0), '0));
		directed.push_back(typed_row(cmd(OP_WRITE, 3, 0, 0, 100, 11, 0), '0));
		// every limit above its size, so each saturates
		regs_at[directed.size()] = '{5'd31, 4'd15, 6'd63};
		directed.push_back(typed_row(cmd(OP_WRITE, 3, 0, 1, -100, 22, 0), '0));
		directed.push_back(typed_row(cmd(OP_WRITE, 3, 0, 2, 32767, -32768, 0), '0));
		directed.push_back(typed_row(cmd(OP_WRITE, 3, 0, 3, -32768, 32767, 1), '0));
		directed.push_back(typed_row(cmd(OP_READ, 3, 0, 3, 0, 0, 0), {16'h7FFF, 16'h8000}));
		directed.push_back(predicted_row(cmd(OP_LOOKUP_LE, 3, 31, 0, 50, 0, 1)));
		directed.push_back(predicted_row(cmd(OP_LOOKUP_GE, 3, 31, 0, 50, 0, 1)));
		directed.push_back(predicted_row(cmd(OP_LOOKUP_LE, 3, 0, 0, -32768, 0, 0)));
		directed.push_back(predicted_row(cmd(OP_LOOKUP_GE, 3, 0, 0, 32767, 0, 0)));
		directed.push_back(predicted_row(cmd(OP_LOOKUP_GE, 7, 31, 0, 1, 0, 1)));
		// tight limits: bank and channel cutoffs, and limits ignored when off
		regs_at[directed.size()] = '{5'd2, 4'd3, 6'd5};
		directed.push_back(typed_row(cmd(OP_LOOKUP_LE, 3, 0, 0, -32768, 0, 1), '0));
		directed.push_back(predicted_row(cmd(OP_LOOKUP_LE, 3, 0, 0, -32768, 0, 0)));
		directed.push_back(typed_row(cmd(OP_LOOKUP_GE, 2, 5, 0, 0, 0, 1), '0));
		directed.push_back(predicted_row(cmd(OP_LOOKUP_GE, 3, 31, 0, 50, 0, 0)));
		directed.push_back(predicted_row(cmd(OP_LOOKUP_LE, 2, 4, 0, 0, 0, 1)));
		directed.push_back(predicted_row(cmd(OP_READ, 3, 0, 1, 0, 0, 0)));
		regs_at[directed.size()] = '{5'd0, 4'd0, 6'd0};
		directed.push_back(typed_row(cmd(OP_LOOKUP_LE, 3, 0, 0, 32767, 0, 0), '0));
		directed.push_back(typed_row(cmd(OP_LOOKUP_GE, 3, 0, 0, -32768, 0, 0), '0));
		directed.push_back(typed_row(cmd(OP_WRITE, 5, 0, 15, 5, -5, 0), '0));
		directed.push_back(typed_row(cmd(OP_READ, 5, 0, 15, 0, 0, 0), {16'hFFFB, 16'h0005}));

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			if (regs_at.exists(i)) begin
				settle();
				program_regs(regs_at[i]);
			end
			send_word(directed[i].word, pick_gap(), directed[i].known, directed[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: plan = '{5'd16, 4'd8, 6'd32};
				1: plan = '{5'd31, 4'd15, 6'd63};
				2: plan = '{5'd1, 4'd8, 6'd32};
				default: plan = '{5'($urandom_range(0, 20)), 4'($urandom), 6'($urandom)};
			endcase
			settle();
			program_regs(plan);
			// one phase runs back to back with no idle cycles
			quiet = (p == 2);
			for (int k = 0; k < PHASE_WORDS; k++) begin
				w.bank = 3'($urandom);
				w.channel = 5'($urandom);
				w.row = 4'($urandom);
				w.entry_value = 16'($urandom);
				w.use_active_limits = 1'($urandom);
				r = $urandom_range(0, 19);
				if (r < 5)
					w.operation = OP_WRITE;
				else if (r < 8)
					w.operation = OP_READ;
				else if (r < 14)
					w.operation = OP_LOOKUP_LE;
				else
					w.operation = OP_LOOKUP_GE;
				w.sample_key = pick_key(w.bank);
				if (!quiet && $urandom_range(0, 99) == 0)
					settle();
				send_word(w, quiet ? 0 : pick_gap(), 1'b0, '0);
			end
		end

		settle();
		$display("covered %0d commands over %0d register settings, %0d lookups hit a row",
			n_words, n_settings, n_hits);
		$display("checked %0d result words, %0d mismatches", n_checked, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[sim.f]
src/bstl_pkg.sv
src/bstl_ram.sv
src/bstl_seq.sv
src/banked_stepwise_threshold_lookup.sv
src/bstl_chk.sv
bench/tb_banked_stepwise_threshold_lookup.sv
